// ===== rtl/rcd_pkg.sv =====
// Shared types and codes of the RTMP chunk deframer.
package rcd_pkg;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_ABORT   = 2'd2;
	localparam logic [1:0] KIND_ORPHAN  = 2'd3;

	// Chunk header fmt codes.
	localparam logic [1:0] FMT_FULL   = 2'd0;
	localparam logic [1:0] FMT_NOSID  = 2'd1;
	localparam logic [1:0] FMT_STAMP  = 2'd2;
	localparam logic [1:0] FMT_CONT   = 2'd3;

	// Message type of a set-chunk-size control message.
	localparam logic [7:0] TYPE_SET_CHUNK = 8'd1;

	localparam logic [23:0] SEG_LIMIT_RESET = 24'd128;

	// Raw byte held in the input stage.
	typedef struct packed {
		logic       valid;
		logic [7:0] in_byte;
	} item_t;

	// One result item of the deframer.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [16:0] stream_id;
		logic [1:0]  header_fmt;
		logic [7:0]  message_type;
		logic [23:0] message_length;
		logic [23:0] timestamp;
		logic        first_of_message;
		logic        last_of_message;
		logic        set_size_msg;
	} result_t;

endpackage

// ===== rtl/rcd_byte_reg.sv =====
// Input stage: holds one raw byte until the parser takes it.
module rcd_byte_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [7:0]    s_axis_tdata,   // [7:0] in_byte
	input  logic          take,
	output rcd_pkg::item_t item
);

	logic       valid_q;
	logic [7:0] byte_q;

	assign s_axis_tready = !valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_q <= s_axis_tdata;
		end
	end

	assign item.valid   = valid_q;
	assign item.in_byte = byte_q;

endmodule

// ===== rtl/rcd_parser.sv =====
// Header parser and payload counter: all deframing state and the per-byte decision.
module rcd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  rcd_pkg::item_t   item,
	input  logic             step,
	input  logic             cfg_we,
	input  logic [23:0]      cfg_data,
	output logic             has_result,
	output rcd_pkg::result_t result
);

	localparam logic [2:0] PH_BH0 = 3'd0;
	localparam logic [2:0] PH_BH1 = 3'd1;
	localparam logic [2:0] PH_BH2 = 3'd2;
	localparam logic [2:0] PH_MSG = 3'd3;
	localparam logic [2:0] PH_EXT = 3'd4;
	localparam logic [2:0] PH_PAY = 3'd5;

	localparam logic [3:0]  HDR_LEN_FULL  = 4'd11;
	localparam logic [3:0]  HDR_LEN_NOSID = 4'd7;
	localparam logic [3:0]  HDR_LEN_STAMP = 4'd3;
	localparam logic [3:0]  EXT_LEN       = 4'd4;
	localparam logic [3:0]  STAMP_END     = 4'd3;
	localparam logic [3:0]  LENGTH_END    = 4'd6;
	localparam logic [3:0]  TYPE_POS      = 4'd6;
	localparam logic [23:0] STAMP_ESCAPE  = 24'hFFFFFF;
	localparam logic [16:0] STREAM_BASE   = 17'd64;

	function automatic logic [23:0] chunk_take(input logic [23:0] left,
	                                           input logic [23:0] size);
		return (size != 24'd0 && left > size) ? size : left;
	endfunction

	function automatic rcd_pkg::result_t make_result(
		input logic [1:0]  kind,
		input logic [7:0]  data,
		input logic [16:0] sid,
		input logic [1:0]  fmt,
		input logic [7:0]  mtype,
		input logic [23:0] mlen,
		input logic [23:0] stamp,
		input logic        first,
		input logic        last
	);
		rcd_pkg::result_t r;
		r.kind             = kind;
		r.data             = data;
		r.stream_id        = sid;
		r.header_fmt       = fmt;
		r.message_type     = mtype;
		r.message_length   = mlen;
		r.timestamp        = stamp;
		r.first_of_message = first;
		r.last_of_message  = last;
		r.set_size_msg     = (kind == rcd_pkg::KIND_PAYLOAD || kind == rcd_pkg::KIND_EMPTY)
		                     && mtype == rcd_pkg::TYPE_SET_CHUNK;
		return r;
	endfunction

	logic [23:0] seg_limit_q;
	logic [2:0]  phase_q, phase_d;
	logic [3:0]  hc_q, hc_d, hc_inc, hdr_len;
	logic [1:0]  fmt_q, fmt_d;
	logic [16:0] stream_q, stream_d;
	logic [23:0] stamp_q, stamp_d;
	logic [23:0] len_q, len_d;
	logic [7:0]  type_q, type_d;
	logic [23:0] slen_q, slen_d;
	logic [7:0]  stype_q, stype_d;
	logic        open_q, open_d;
	logic [23:0] mleft_q, mleft_d;
	logic [23:0] cleft_q, cleft_d;
	logic        firstp_q, firstp_d;
	logic        do_basic, do_begin;
	logic [7:0]  b;

	assign b       = item.in_byte;
	assign hc_inc  = hc_q + 4'd1;
	assign hdr_len = (fmt_q == rcd_pkg::FMT_FULL)  ? HDR_LEN_FULL :
	                 (fmt_q == rcd_pkg::FMT_NOSID) ? HDR_LEN_NOSID : HDR_LEN_STAMP;

	always_comb begin
		phase_d    = phase_q;
		hc_d       = hc_q;
		fmt_d      = fmt_q;
		stream_d   = stream_q;
		stamp_d    = stamp_q;
		len_d      = len_q;
		type_d     = type_q;
		slen_d     = slen_q;
		stype_d    = stype_q;
		open_d     = open_q;
		mleft_d    = mleft_q;
		cleft_d    = cleft_q;
		firstp_d   = firstp_q;
		do_basic   = 1'b0;
		do_begin   = 1'b0;
		has_result = 1'b0;
		result     = '0;

		unique case (phase_q)
			PH_BH0: begin
				if (b[7:6] == rcd_pkg::FMT_CONT && !open_q) begin
					// continuation with nothing to continue: flag it, stay in basic header
					fmt_d            = rcd_pkg::FMT_CONT;
					stream_d         = {11'd0, b[5:0]};
					has_result       = 1'b1;
					result.kind      = rcd_pkg::KIND_ORPHAN;
					result.stream_id = {11'd0, b[5:0]};
					result.header_fmt = rcd_pkg::FMT_CONT;
				end else begin
					if (b[7:6] != rcd_pkg::FMT_CONT && open_q) begin
						has_result = 1'b1;
						result = make_result(rcd_pkg::KIND_ABORT, 8'd0, stream_q, fmt_q,
						                     type_q, len_q, stamp_q, 1'b0, 1'b0);
						open_d   = 1'b0;
						firstp_d = 1'b0;
						mleft_d  = '0;
						cleft_d  = '0;
					end
					fmt_d    = b[7:6];
					stream_d = {11'd0, b[5:0]};
					if (b[5:1] == 5'd0) begin
						phase_d = PH_BH1;
					end else begin
						do_basic = 1'b1;
					end
				end
			end
			PH_BH1: begin
				stream_d = {9'd0, b} + STREAM_BASE;
				if (stream_q == 17'd1) begin
					phase_d = PH_BH2;
				end else begin
					do_basic = 1'b1;
				end
			end
			PH_BH2: begin
				stream_d = stream_q + {1'b0, b, 8'd0};
				do_basic = 1'b1;
			end
			PH_MSG: begin
				if (hc_q < STAMP_END) begin
					stamp_d = {stamp_q[15:0], b};
				end else if (hc_q < LENGTH_END) begin
					len_d = {len_q[15:0], b};
				end else if (hc_q == TYPE_POS) begin
					type_d = b;
				end
				if (hc_inc < hdr_len) begin
					hc_d = hc_inc;
				end else begin
					if (fmt_q == rcd_pkg::FMT_STAMP) begin
						len_d  = slen_q;
						type_d = stype_q;
					end else begin
						slen_d  = len_d;
						stype_d = type_d;
					end
					hc_d = '0;
					if (stamp_d == STAMP_ESCAPE) begin
						phase_d = PH_EXT;
					end else begin
						do_begin = 1'b1;
					end
				end
			end
			PH_EXT: begin
				if (hc_inc < EXT_LEN) begin
					hc_d = hc_inc;
				end else begin
					hc_d     = '0;
					do_begin = 1'b1;
				end
			end
			PH_PAY: begin
				has_result = 1'b1;
				result = make_result(rcd_pkg::KIND_PAYLOAD, b, stream_q, fmt_q, type_q,
				                     len_q, stamp_q, firstp_q, mleft_q <= 24'd1);
				firstp_d = 1'b0;
				if (mleft_q != 24'd0) begin
					mleft_d = mleft_q - 24'd1;
				end
				if (cleft_q != 24'd0) begin
					cleft_d = cleft_q - 24'd1;
				end
				if (mleft_d == 24'd0) begin
					open_d  = 1'b0;
					cleft_d = '0;
					phase_d = PH_BH0;
				end else if (cleft_d == 24'd0) begin
					phase_d = PH_BH0;
				end
			end
			default: begin
				phase_d = PH_BH0;
			end
		endcase

		// basic header complete: continuation resumes payload, others read a message header
		if (do_basic) begin
			if (fmt_d == rcd_pkg::FMT_CONT) begin
				cleft_d = chunk_take(mleft_d, seg_limit_q);
				phase_d = PH_PAY;
			end else begin
				hc_d    = '0;
				phase_d = PH_MSG;
			end
		end

		// message header complete: open the message, or report it empty
		if (do_begin) begin
			mleft_d = len_d;
			if (len_d == 24'd0) begin
				open_d     = 1'b0;
				firstp_d   = 1'b0;
				phase_d    = PH_BH0;
				has_result = 1'b1;
				result = make_result(rcd_pkg::KIND_EMPTY, 8'd0, stream_d, fmt_d, type_d,
				                     len_d, stamp_d, 1'b0, 1'b1);
			end else begin
				open_d   = 1'b1;
				firstp_d = 1'b1;
				cleft_d  = chunk_take(len_d, seg_limit_q);
				phase_d  = PH_PAY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_limit_q <= rcd_pkg::SEG_LIMIT_RESET;
		end else if (cfg_we) begin
			seg_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BH0;
			hc_q     <= '0;
			fmt_q    <= '0;
			stream_q <= '0;
			stamp_q  <= '0;
			len_q    <= '0;
			type_q   <= '0;
			slen_q   <= '0;
			stype_q  <= '0;
			open_q   <= 1'b0;
			mleft_q  <= '0;
			cleft_q  <= '0;
			firstp_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			hc_q     <= hc_d;
			fmt_q    <= fmt_d;
			stream_q <= stream_d;
			stamp_q  <= stamp_d;
			len_q    <= len_d;
			type_q   <= type_d;
			slen_q   <= slen_d;
			stype_q  <= stype_d;
			open_q   <= open_d;
			mleft_q  <= mleft_d;
			cleft_q  <= cleft_d;
			firstp_q <= firstp_d;
		end
	end

	// payload phase always has bytes left in both the message and the chunk
	a_pay_counts: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAY |-> (mleft_q != 24'd0 && cleft_q != 24'd0))
		else $error("payload phase with an exhausted counter");

	a_first_needs_open: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> !firstp_q)
		else $error("first-byte mark pending with no open message");

	a_hdr_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_MSG |-> hc_q < HDR_LEN_FULL)
		else $error("message header count overran");

endmodule

// ===== rtl/rcd_out_reg.sv =====
// Result register: holds one result until the receiver takes it.
module rcd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  rcd_pkg::result_t result,
	output logic             free,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output rcd_pkg::result_t held
);

	logic valid_q;

	assign free          = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			held <= result;
		end
	end

endmodule

// ===== rtl/rtmp_chunk_deframer_core.sv =====
// Top level of the RTMP chunk deframer: byte stream in, tagged payload stream out.
//
// Feed the raw chunk stream one byte per transaction on the s_axis channel. Each
// byte yields zero or one transaction on m_axis: a payload byte with the fields
// of its message, an empty-message marker, an abort of the open message, or an
// orphan-continuation error (see the tuser kind code). tlast marks the byte that
// completes a message, and the empty-message marker.
// Write the chunk size on the cfg channel (always ready); zero disables
// splitting. Write it only while the deframer is idle; it applies from the next
// chunk start.
// Path: a byte taken is held in the input byte register, parsed by combinational
// logic, and its result registered in the result register, which offers it on
// m_axis.
// Throughput: one byte per cycle while m_axis takes the results; the parser is a
// single pass of logic between the input byte register and the result register.
// Stalls: while m_axis is held off with a result waiting, one more byte may be
// taken into the input register; a byte with no result passes regardless.
// Reset: all parsing state clears, the chunk size returns to 128, both channels
// come up empty and the next byte is read as a basic header.
module rtmp_chunk_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] data, [24:8] stream_id, [26:25] header_fmt, [34:27] message_type,
	// [58:35] message_length, [82:59] timestamp, [87:83] zero
	output logic [87:0] m_axis_tdata,
	// [1:0] kind, [2] first_of_message, [3] set-chunk-size message flag
	output logic [3:0]  m_axis_tuser,
	output logic        m_axis_tlast,   // last_of_message
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data        // maximum payload bytes per chunk
);

	rcd_pkg::item_t   item;
	rcd_pkg::result_t result;
	rcd_pkg::result_t held;
	logic             has_result;
	logic             out_free;
	logic             advance;

	assign cfg_ready = 1'b1;

	// Advance the held byte when its result, if any, has room in the result register.
	assign advance = item.valid && (!has_result || out_free);

	rcd_byte_reg u_byte_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.take          (advance),
		.item          (item)
	);

	rcd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.step       (advance),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.has_result (has_result),
		.result     (result)
	);

	rcd_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && has_result),
		.result        (result),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.held          (held)
	);

	assign m_axis_tdata = {5'd0, held.timestamp, held.message_length, held.message_type,
	                       held.header_fmt, held.stream_id, held.data};
	assign m_axis_tuser = {held.set_size_msg, held.first_of_message, held.kind};
	assign m_axis_tlast = held.last_of_message;

	// a result leaving the parser is always offered on the next cycle
	a_result_offered: assert property (@(posedge clk) disable iff (!arst_n)
		advance && has_result |=> m_axis_tvalid)
		else $error("parsed result not registered");

	// a held byte that cannot advance is kept
	a_byte_kept: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && !advance |=> item.valid && $stable(item.in_byte))
		else $error("input byte lost while stalled");

endmodule

// ===== test/rtmp_chunk_deframer_core_tb.sv =====
// Self-checking testbench of the RTMP chunk deframer: byte stream in, tagged results checked.
`timescale 1ns / 100ps

module rtmp_chunk_deframer_core_tb;

	localparam logic [3:0]  HDR_LEN_FULL   = 4'd11;
	localparam logic [3:0]  HDR_LEN_NO_ID  = 4'd7;
	localparam logic [3:0]  HDR_LEN_STAMP  = 4'd3;
	localparam logic [3:0]  EXT_STAMP_LEN  = 4'd4;
	localparam logic [23:0] STAMP_ALL_ONES = 24'hFFFFFF;
	localparam logic [16:0] STREAM_OFFSET  = 17'd64;

	localparam int ITEMS_PER_PHASE = 250;
	localparam int NUM_PHASES      = 6;

	// Parse phases of the model.
	localparam logic [2:0] P_BASIC0   = 3'd0;
	localparam logic [2:0] P_BASIC1   = 3'd1;
	localparam logic [2:0] P_BASIC2   = 3'd2;
	localparam logic [2:0] P_HEADER   = 3'd3;
	localparam logic [2:0] P_EXTSTAMP = 3'd4;
	localparam logic [2:0] P_PAYLOAD  = 3'd5;

	// Tracks the deframer's parse state and keeps the results it must produce.
	class deframer_scoreboard;
		logic [2:0]   ph;
		logic [3:0]   hdr_count;
		logic [1:0]   fmt;
		logic [16:0]  stream;
		logic [23:0]  stamp, msg_length, saved_length, msg_left, chunk_left, seg_limit;
		logic [7:0]   mtype, saved_type;
		logic         msg_open, first_pend;
		rcd_pkg::result_t expected_q[$];
		int           errors;

		function new();
			ph = P_BASIC0;
			hdr_count = '0;
			fmt = rcd_pkg::FMT_FULL;
			stream = '0;
			stamp = '0;
			msg_length = '0;
			mtype = '0;
			saved_length = '0;
			saved_type = '0;
			msg_open = 1'b0;
			msg_left = '0;
			chunk_left = '0;
			first_pend = 1'b0;
			seg_limit = rcd_pkg::SEG_LIMIT_RESET;
			errors = 0;
		endfunction

		function void set_seg_limit(logic [23:0] v);
			seg_limit = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void push_result(logic [1:0] k, logic [7:0] d, logic fi, logic la);
			rcd_pkg::result_t r;
			r.kind = k;
			r.data = d;
			r.stream_id = stream;
			r.header_fmt = fmt;
			r.message_type = mtype;
			r.message_length = msg_length;
			r.timestamp = stamp;
			r.first_of_message = fi;
			r.last_of_message = la;
			r.set_size_msg = (k <= rcd_pkg::KIND_EMPTY) && (mtype == rcd_pkg::TYPE_SET_CHUNK);
			expected_q = {expected_q, r};
		endfunction

		function void begin_chunk();
			chunk_left = (seg_limit != 24'd0 && msg_left > seg_limit) ? seg_limit : msg_left;
			ph = P_PAYLOAD;
		endfunction

		function void begin_message();
			msg_left = msg_length;
			if (msg_length == 24'd0) begin
				msg_open = 1'b0;
				first_pend = 1'b0;
				ph = P_BASIC0;
				push_result(rcd_pkg::KIND_EMPTY, 8'd0, 1'b0, 1'b1);
			end else begin
				msg_open = 1'b1;
				first_pend = 1'b1;
				begin_chunk();
			end
		endfunction

		function void basic_done();
			if (fmt == rcd_pkg::FMT_CONT) begin
				begin_chunk();
			end else begin
				hdr_count = '0;
				ph = P_HEADER;
			end
		endfunction

		// Advance the parse by one accepted byte.
		function void note_byte(logic [7:0] b);
			rcd_pkg::result_t r;
			logic [3:0]       hlen;
			unique case (ph)
			P_BASIC0: begin
				if (b[7:6] == rcd_pkg::FMT_CONT && !msg_open) begin
					// orphan continuation: report and stay on the basic header
					fmt = rcd_pkg::FMT_CONT;
					stream = {11'd0, b[5:0]};
					r = '0;
					r.kind = rcd_pkg::KIND_ORPHAN;
					r.stream_id = {11'd0, b[5:0]};
					r.header_fmt = rcd_pkg::FMT_CONT;
					expected_q = {expected_q, r};
				end else begin
					if (b[7:6] != rcd_pkg::FMT_CONT && msg_open) begin
						push_result(rcd_pkg::KIND_ABORT, 8'd0, 1'b0, 1'b0);
						msg_open = 1'b0;
						first_pend = 1'b0;
						msg_left = '0;
						chunk_left = '0;
					end
					fmt = b[7:6];
					stream = {11'd0, b[5:0]};
					if (b[5:0] == 6'd0 || b[5:0] == 6'd1)
						ph = P_BASIC1;
					else
						basic_done();
				end
			end
			P_BASIC1: begin
				if (stream == 17'd1) begin
					stream = {9'd0, b} + STREAM_OFFSET;
					ph = P_BASIC2;
				end else begin
					stream = {9'd0, b} + STREAM_OFFSET;
					basic_done();
				end
			end
			P_BASIC2: begin
				stream = stream + {1'b0, b, 8'd0};
				basic_done();
			end
			P_HEADER: begin
				hlen = (fmt == rcd_pkg::FMT_FULL) ? HDR_LEN_FULL :
					(fmt == rcd_pkg::FMT_NOSID) ? HDR_LEN_NO_ID : HDR_LEN_STAMP;
				if (hdr_count < 4'd3)
					stamp = {stamp[15:0], b};
				else if (hdr_count < 4'd6)
					msg_length = {msg_length[15:0], b};
				else if (hdr_count == 4'd6)
					mtype = b;
				hdr_count = hdr_count + 4'd1;
				if (hdr_count >= hlen) begin
					if (fmt == rcd_pkg::FMT_STAMP) begin
						msg_length = saved_length;
						mtype = saved_type;
					end else begin
						saved_length = msg_length;
						saved_type = mtype;
					end
					hdr_count = '0;
					if (stamp == STAMP_ALL_ONES)
						ph = P_EXTSTAMP;
					else
						begin_message();
				end
			end
			P_EXTSTAMP: begin
				hdr_count = hdr_count + 4'd1;
				if (hdr_count >= EXT_STAMP_LEN) begin
					hdr_count = '0;
					begin_message();
				end
			end
			P_PAYLOAD: begin
				push_result(rcd_pkg::KIND_PAYLOAD, b, first_pend, msg_left <= 24'd1);
				first_pend = 1'b0;
				if (msg_left > 24'd0)
					msg_left = msg_left - 24'd1;
				if (chunk_left > 24'd0)
					chunk_left = chunk_left - 24'd1;
				if (msg_left == 24'd0) begin
					msg_open = 1'b0;
					chunk_left = '0;
					ph = P_BASIC0;
				end else if (chunk_left == 24'd0) begin
					ph = P_BASIC0;
				end
			end
			default: ph = P_BASIC0;
			endcase
		endfunction

		function void compare(string name, logic [23:0] want, logic [23:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		// Compare one accepted result with the oldest expectation.
		function void check_result(rcd_pkg::result_t got);
			rcd_pkg::result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result expected none actual kind %0h data %0h stream %0h",
					$time, got.kind, got.data, got.stream_id);
				errors++;
				return;
			end
			want = expected_q[0];
			expected_q.delete(0);
			compare("kind", 24'(want.kind), 24'(got.kind));
			compare("data", 24'(want.data), 24'(got.data));
			compare("stream_id", 24'(want.stream_id), 24'(got.stream_id));
			compare("header_fmt", 24'(want.header_fmt), 24'(got.header_fmt));
			compare("message_type", 24'(want.message_type), 24'(got.message_type));
			compare("message_length", want.message_length, got.message_length);
			compare("timestamp", want.timestamp, got.timestamp);
			compare("first_of_message", 24'(want.first_of_message),
				24'(got.first_of_message));
			compare("last_of_message", 24'(want.last_of_message), 24'(got.last_of_message));
			compare("set_size_msg", 24'(want.set_size_msg), 24'(got.set_size_msg));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [23:0] cfg_data = 24'd0;

	deframer_scoreboard sb;

	// Idle percentages of the sender and the receiver.
	int send_idle = 36;
	int recv_idle = 51;
	int items_sent = 0;

	// Chunk stream id of the message being generated, with its extension bytes.
	logic [5:0] cs_id;
	logic [7:0] cs_lo, cs_hi;

	// Hand-picked opening bytes: fmt 2 after reset (empty message from the zeroed
	// saved length), an orphan continuation, a fmt 1 chunk with the largest
	// three-byte stream id, an extended timestamp and set-chunk-size type, then
	// a fmt 0 header on a two-byte id that closes with zero length.
	logic [7:0] directed_q[$] = {
		8'h82, 8'h00, 8'h00, 8'h05,
		8'hFF,
		8'h41, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h03, 8'h01,
		8'h11, 8'h22, 8'h33, 8'h44, 8'h00, 8'hFF,
		8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00
	};

	rtmp_chunk_deframer_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Receiver: check each result transaction at the edge that takes it, then
	// choose whether to stall the next cycle.
	always @(posedge clk) begin : result_monitor
		rcd_pkg::result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tuser[1:0];
			got.first_of_message = m_axis_tuser[2];
			got.set_size_msg = m_axis_tuser[3];
			got.last_of_message = m_axis_tlast;
			got.data = m_axis_tdata[7:0];
			got.stream_id = m_axis_tdata[24:8];
			got.header_fmt = m_axis_tdata[26:25];
			got.message_type = m_axis_tdata[34:27];
			got.message_length = m_axis_tdata[58:35];
			got.timestamp = m_axis_tdata[82:59];
			sb.check_result(got);
		end
		m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	// Offer one byte, idling first at random; hold tvalid high afterwards so
	// that back-to-back bytes never drop it within a step.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_byte(b);
		items_sent++;
	endtask

	task automatic hold_off();
		s_axis_tvalid <= 1'b0;
	endtask

	// Wait until every expected result is out, then let the pipeline empty.
	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_seg_limit(input logic [23:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_seg_limit(v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Basic header with the current stream id, in one, two or three bytes.
	task automatic send_basic(input logic [1:0] f);
		send_byte({f, cs_id});
		if (cs_id == 6'd0 || cs_id == 6'd1)
			send_byte(cs_lo);
		if (cs_id == 6'd1)
			send_byte(cs_hi);
	endtask

	task automatic pick_stream();
		case ($urandom_range(9))
		0: cs_id = 6'd0;
		1: cs_id = 6'd1;
		2: cs_id = 6'd63;
		default: cs_id = 6'($urandom_range(2, 63));
		endcase
		cs_lo = 8'($urandom_range(255));
		cs_hi = 8'($urandom_range(255));
	endtask

	// Mostly short messages, a few spanning several chunks, now and then empty.
	function automatic logic [23:0] pick_length();
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return 24'd0;
		else if (r < 15)
			return 24'($urandom_range(1, 24));
		else if (r < 19)
			return 24'($urandom_range(25, 300));
		return 24'($urandom_range(301, 600));
	endfunction

	// Bring the parse back to a closed message on a basic header: pad headers
	// with zeros, fill payload with random bytes and continue with fmt 3 chunks.
	task automatic settle();
		while (sb.ph != P_BASIC0 || sb.msg_open) begin
			if (sb.ph == P_PAYLOAD)
				send_byte(8'($urandom_range(255)));
			else if (sb.ph == P_BASIC0)
				send_basic(rcd_pkg::FMT_CONT);
			else
				send_byte(8'h00);
		end
	endtask

	// One well-formed message; when cut short, drop it after its first chunk so
	// that the next header aborts it.
	task automatic gen_message(input bit cut_short);
		logic [1:0]  f;
		logic [23:0] ts, len;
		int          pick;
		pick = $urandom_range(9);
		f = (pick < 5) ? rcd_pkg::FMT_FULL : (pick < 8) ? rcd_pkg::FMT_NOSID :
			rcd_pkg::FMT_STAMP;
		pick_stream();
		ts = ($urandom_range(7) == 0) ? STAMP_ALL_ONES : 24'($urandom);
		send_basic(f);
		send_byte(ts[23:16]);
		send_byte(ts[15:8]);
		send_byte(ts[7:0]);
		if (f != rcd_pkg::FMT_STAMP) begin
			len = pick_length();
			send_byte(len[23:16]);
			send_byte(len[15:8]);
			send_byte(len[7:0]);
			if ($urandom_range(5) == 0)
				send_byte(rcd_pkg::TYPE_SET_CHUNK);
			else
				send_byte(8'($urandom_range(255)));
			if (f == rcd_pkg::FMT_FULL)
				repeat (4) send_byte(8'($urandom_range(255)));
		end
		if (ts == STAMP_ALL_ONES)
			repeat (4) send_byte(8'($urandom_range(255)));
		if (cut_short) begin
			while (sb.ph == P_PAYLOAD)
				send_byte(8'($urandom_range(255)));
		end else begin
			settle();
		end
	endtask

	// Random bytes; stop before they could set a message length, then settle.
	task automatic send_noise();
		int k;
		k = $urandom_range(1, 6);
		while (k > 0 && sb.ph != P_PAYLOAD && !(sb.ph == P_HEADER && sb.hdr_count >= 4'd3)) begin
			send_byte(8'($urandom_range(255)));
			k--;
		end
		settle();
	endtask

	task automatic run_phase(input int n_items);
		int         stop_at, pick;
		logic [5:0] id;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(19);
			id = 6'($urandom_range(63));
			if (pick < 14) begin
				gen_message(1'b0);
			end else if (pick < 16) begin
				gen_message(1'b1);
			end else if (pick < 18 && !sb.msg_open) begin
				send_byte({rcd_pkg::FMT_CONT, id});
			end else begin
				send_noise();
			end
		end
		settle();
	endtask

	initial begin
		logic [23:0] size;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed bytes run with the reset chunk size.
		foreach (directed_q[i])
			send_byte(directed_q[i]);
		settle();
		hold_off();
		wait_drained();

		// Each phase: an idle mix (changed every second phase) and a new chunk size, written only once drained.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p / 2)
			0: begin
				send_idle = 36;
				recv_idle = 51;
			end
			1: begin
				send_idle = 51;
				recv_idle = 36;
			end
			default: begin
				send_idle = 0;
				recv_idle = 0;
			end
			endcase
			case (p)
			0: size = 24'hFFFFFF;
			1: size = 24'd1;
			2: size = 24'($urandom_range(2, 20));
			3: size = 24'd0;
			4: size = rcd_pkg::SEG_LIMIT_RESET;
			default: size = 24'($urandom_range(21, 300));
			endcase
			write_seg_limit(size);
			run_phase(ITEMS_PER_PHASE);
			hold_off();
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== rtmp_chunk_deframer_core.f =====
rtl/rcd_pkg.sv
rtl/rcd_byte_reg.sv
rtl/rcd_parser.sv
rtl/rcd_out_reg.sv
rtl/rtmp_chunk_deframer_core.sv
test/rtmp_chunk_deframer_core_tb.sv
